FILE: design/mrm_pkg.sv
// ----------------------------------------------------------------------------
// mrm_pkg
// shared types, codes and the crc step of the modbus rtu master
// ----------------------------------------------------------------------------
`default_nettype none

package mrm_pkg;

  typedef enum logic [1:0] {
    EV_REQUEST = 2'd0,
    EV_RX_BYTE = 2'd1,
    EV_TICK    = 2'd2,
    EV_TX_DONE = 2'd3
  } evt_e;

  localparam logic [1:0] FS_READ  = 2'd0;
  localparam logic [1:0] FS_WRITE = 2'd1;
  localparam logic [1:0] FS_COIL  = 2'd2;
  localparam logic [1:0] FS_NONE  = 2'd3;

  localparam logic [7:0] FC_READ_INPUT = 8'h04;
  localparam logic [7:0] FC_WRITE_REG  = 8'h06;
  localparam logic [7:0] FC_WRITE_COIL = 8'h05;
  localparam logic [7:0] COIL_ON       = 8'hFF;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_TIMEOUT   = 3'd1;
  localparam logic [2:0] ST_CRC_ERR   = 3'd2;
  localparam logic [2:0] ST_EXCEPTION = 3'd3;
  localparam logic [2:0] ST_BUSY      = 3'd4;
  localparam logic [2:0] ST_SHORT     = 3'd5;

  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam int          EXC_BIT  = 7;
  localparam int          MIN_REPLY = 4;

  localparam logic [15:0] GAP_RESET     = 16'd176;
  localparam logic [23:0] TIMEOUT_RESET = 24'd50000;

  localparam logic ADDR_GAP     = 1'b0;
  localparam logic ADDR_TIMEOUT = 1'b1;

  typedef struct packed {
    evt_e            kind;
    logic [1:0]      fsel;
    logic [5:0][7:0] frame;
    logic [7:0]      count;
    logic [7:0]      rx_byte;
  } cmd_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  tx_byte;
    logic [2:0]  status;
    logic [15:0] reg_word;
    logic        data_valid;
    logic        last;
    logic        te;
  } res_t;

  function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

  function automatic res_t mk_status(input logic [2:0] st, input logic te);
    res_t r;
    r = '0;
    r.kind   = 1'b1;
    r.status = st;
    r.last   = 1'b1;
    r.te     = te;
    return r;
  endfunction

  function automatic res_t mk_tx(input logic [7:0] b, input logic last);
    res_t r;
    r = '0;
    r.tx_byte = b;
    r.last    = last;
    r.te      = 1'b1;
    return r;
  endfunction

  function automatic res_t mk_word(input logic [15:0] w, input logic last);
    res_t r;
    r = '0;
    r.kind       = 1'b1;
    r.reg_word   = w;
    r.data_valid = 1'b1;
    r.last       = last;
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: design/mrm_if.sv
// ----------------------------------------------------------------------------
// mrm_if
// event and result channels of the modbus rtu master
// ----------------------------------------------------------------------------
`default_nettype none

interface mrm_evt_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_kind;
  logic [7:0]  slave_addr;
  logic [1:0]  function_select;
  logic [15:0] reg_addr;
  logic [15:0] request_value;
  logic [7:0]  rx_byte;

  modport source (output valid, event_kind, slave_addr, function_select, reg_addr,
                  request_value, rx_byte, input ready);
  modport sink (input valid, event_kind, slave_addr, function_select, reg_addr,
                request_value, rx_byte, output ready);
endinterface

interface mrm_res_if;
  logic        valid;
  logic        ready;
  logic        item_kind;
  logic [7:0]  tx_byte;
  logic [2:0]  status;
  logic [15:0] reg_word;
  logic        data_valid;
  logic        last_of_run;
  logic        transmit_enable;

  modport source (output valid, item_kind, tx_byte, status, reg_word, data_valid,
                  last_of_run, transmit_enable, input ready);
  modport sink (input valid, item_kind, tx_byte, status, reg_word, data_valid,
                last_of_run, transmit_enable, output ready);
endinterface

`default_nettype wire

FILE: design/mrm_ram.sv
// ----------------------------------------------------------------------------
// mrm_ram
// generic single-write, single-read ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module mrm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: design/mrm_queue.sv
// ----------------------------------------------------------------------------
// mrm_queue
// two-entry command queue between front and back end
// ----------------------------------------------------------------------------
`default_nettype none

module mrm_queue #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  vld_o,
  output logic      [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0] ent_q [2];
  logic             wp_q, wp_d, rp_q, rp_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign vld_o   = (cnt_q != 2'd0);
  assign data_o  = ent_q[rp_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && vld_o;

  always_comb begin
    wp_d  = do_push ? ~wp_q : wp_q;
    rp_d  = do_pop ? ~rp_q : rp_q;
    cnt_d = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wp_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

FILE: design/mrm_front.sv
// ----------------------------------------------------------------------------
// mrm_front
// accepts events, builds request frame bytes and queues commands
// ----------------------------------------------------------------------------
`default_nettype none

module mrm_front #(
  parameter int MAX_READ_REGS = 32
) (
  mrm_evt_if.sink             evt_i,
  output logic                push_o,
  output mrm_pkg::cmd_t       cmd_o,
  input  wire logic           full_i
);
  import mrm_pkg::*;

  localparam logic [7:0] MaxCnt = 8'(MAX_READ_REGS);

  logic [7:0] cnt8;

  assign evt_i.ready = !full_i;
  assign push_o      = evt_i.valid;

  always_comb begin
    cnt8 = (evt_i.request_value[7:0] > MaxCnt) ? MaxCnt : evt_i.request_value[7:0];
    cmd_o          = '0;
    cmd_o.kind     = evt_e'(evt_i.event_kind);
    cmd_o.fsel     = evt_i.function_select;
    cmd_o.rx_byte  = evt_i.rx_byte;
    cmd_o.frame[0] = evt_i.slave_addr;
    cmd_o.frame[2] = evt_i.reg_addr[15:8];
    cmd_o.frame[3] = evt_i.reg_addr[7:0];
    case (evt_i.function_select)
      FS_READ: begin
        cmd_o.frame[1] = FC_READ_INPUT;
        cmd_o.frame[5] = cnt8;
        cmd_o.count    = cnt8;
      end
      FS_WRITE: begin
        cmd_o.frame[1] = FC_WRITE_REG;
        cmd_o.frame[4] = evt_i.request_value[15:8];
        cmd_o.frame[5] = evt_i.request_value[7:0];
      end
      FS_COIL: begin
        cmd_o.frame[1] = FC_WRITE_COIL;
        cmd_o.frame[4] = (evt_i.request_value != 16'd0) ? COIL_ON : 8'h00;
      end
      default: begin
        cmd_o.frame[1] = 8'h00;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: design/mrm_back.sv
// ----------------------------------------------------------------------------
// mrm_back
// transaction sequencer: frame transmit, reply capture, check and read-out
// ----------------------------------------------------------------------------
`default_nettype none

module mrm_back #(
  parameter int RX_BUFFER_DEPTH = 256,
  parameter int MAX_READ_REGS   = 32
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cmd_vld_i,
  input  wire mrm_pkg::cmd_t cmd_i,
  output logic               cmd_pop_o,
  input  wire logic [15:0]   gap_i,
  input  wire logic [23:0]   timeout_i,
  mrm_res_if.source          res_o
);
  import mrm_pkg::*;

  localparam int AW   = $clog2(RX_BUFFER_DEPTH);
  localparam int LW   = $clog2(RX_BUFFER_DEPTH + 1);
  localparam int CW   = $clog2(MAX_READ_REGS + 1);
  localparam int CMPW = ((LW > CW + 2) ? LW : CW + 2) + 1;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'b001,
    MODE_SEND = 3'b010,
    MODE_RECV = 3'b100
  } mode_e;

  typedef enum logic [7:0] {
    S_CMD   = 8'b0000_0001,
    S_TX    = 8'b0000_0010,
    S_RD    = 8'b0000_0100,
    S_CHECK = 8'b0000_1000,
    S_WA    = 8'b0001_0000,
    S_WB    = 8'b0010_0000,
    S_WC    = 8'b0100_0000,
    S_WD    = 8'b1000_0000
  } state_e;

  state_e          state_q, state_d;
  mode_e           mode_q, mode_d;
  logic [5:0][7:0] frame_q, frame_d;
  logic [15:0]     crc_q, crc_d;
  logic [2:0]      idx_q, idx_d;
  logic [1:0]      fsel_q, fsel_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [LW-1:0]   len_q, len_d;
  logic [23:0]     elapsed_q, elapsed_d;
  logic [15:0]     silence_q, silence_d;
  logic [LW-1:0]   rd_ptr_q, rd_ptr_d;
  logic            rd_vld_q, rd_vld_d;
  logic [LW-1:0]   rd_idx_q, rd_idx_d;
  logic            exc_q, exc_d;
  logic [15:0]     got_q, got_d;
  logic [CW-1:0]   k_q, k_d;
  logic [7:0]      hi_q, hi_d, lo_q, lo_d;
  logic            out_vld_q, out_vld_d;
  res_t            out_q, out_d;

  logic            out_free;
  logic            ram_we, ram_re;
  logic [AW-1:0]   ram_raddr;
  logic [7:0]      ram_rdata;
  logic [7:0]      tx_b;
  logic [23:0]     el_n;
  logic [15:0]     sil_n;
  logic [CMPW-1:0] need_len, waddr_w;

  mrm_ram #(.WIDTH(8), .DEPTH(RX_BUFFER_DEPTH)) u_rx_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (len_q[AW-1:0]),
    .wdata_i (cmd_i.rx_byte),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_free                = !out_vld_q || res_o.ready;
  assign res_o.valid             = out_vld_q;
  assign res_o.item_kind         = out_q.kind;
  assign res_o.tx_byte           = out_q.tx_byte;
  assign res_o.status            = out_q.status;
  assign res_o.reg_word          = out_q.reg_word;
  assign res_o.data_valid        = out_q.data_valid;
  assign res_o.last_of_run       = out_q.last;
  assign res_o.transmit_enable   = out_q.te;

  always_comb begin
    state_d   = state_q;
    mode_d    = mode_q;
    frame_d   = frame_q;
    crc_d     = crc_q;
    idx_d     = idx_q;
    fsel_d    = fsel_q;
    cnt_d     = cnt_q;
    len_d     = len_q;
    elapsed_d = elapsed_q;
    silence_d = silence_q;
    rd_ptr_d  = rd_ptr_q;
    rd_vld_d  = 1'b0;
    rd_idx_d  = rd_idx_q;
    exc_d     = exc_q;
    got_d     = got_q;
    k_d       = k_q;
    hi_d      = hi_q;
    lo_d      = lo_q;
    out_vld_d = out_vld_q && !res_o.ready;
    out_d     = out_q;
    cmd_pop_o = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = rd_ptr_q[AW-1:0];
    el_n      = (elapsed_q == 24'hFFFFFF) ? elapsed_q : elapsed_q + 24'd1;
    sil_n     = (silence_q == 16'hFFFF) ? silence_q : silence_q + 16'd1;
    need_len  = CMPW'(MIN_REPLY) + (CMPW'(cnt_q) << 1);
    waddr_w   = CMPW'(2) + (CMPW'(k_q) << 1);
    case (idx_q)
      3'd0:    tx_b = frame_q[0];
      3'd1:    tx_b = frame_q[1];
      3'd2:    tx_b = frame_q[2];
      3'd3:    tx_b = frame_q[3];
      3'd4:    tx_b = frame_q[4];
      3'd5:    tx_b = frame_q[5];
      3'd6:    tx_b = crc_q[7:0];
      default: tx_b = crc_q[15:8];
    endcase

    case (state_q)
      S_CMD: begin
        if (cmd_vld_i && out_free) begin
          cmd_pop_o = 1'b1;
          case (cmd_i.kind)
            EV_REQUEST: begin
              if (mode_q != MODE_IDLE) begin
                out_vld_d = 1'b1;
                out_d     = mk_status(ST_BUSY, mode_q == MODE_SEND);
              end else if (cmd_i.fsel != FS_NONE) begin
                frame_d   = cmd_i.frame;
                crc_d     = CRC_INIT;
                idx_d     = 3'd0;
                fsel_d    = cmd_i.fsel;
                cnt_d     = cmd_i.count[CW-1:0];
                mode_d    = MODE_SEND;
                len_d     = '0;
                elapsed_d = '0;
                silence_d = '0;
                state_d   = S_TX;
              end
            end
            EV_RX_BYTE: begin
              if (mode_q == MODE_RECV && len_q < LW'(RX_BUFFER_DEPTH)) begin
                ram_we    = 1'b1;
                len_d     = len_q + LW'(1);
                silence_d = '0;
              end
            end
            EV_TX_DONE: begin
              if (mode_q == MODE_SEND) begin
                mode_d    = MODE_RECV;
                len_d     = '0;
                silence_d = '0;
              end
            end
            default: begin
              if (mode_q != MODE_IDLE) begin
                elapsed_d = el_n;
                if (el_n > timeout_i) begin
                  mode_d    = MODE_IDLE;
                  out_vld_d = 1'b1;
                  out_d     = mk_status(ST_TIMEOUT, 1'b0);
                end else if (mode_q == MODE_RECV && len_q != '0) begin
                  silence_d = sil_n;
                  if (sil_n > gap_i) begin
                    mode_d = MODE_IDLE;
                    if (len_q < LW'(MIN_REPLY)) begin
                      out_vld_d = 1'b1;
                      out_d     = mk_status(ST_SHORT, 1'b0);
                    end else begin
                      crc_d    = CRC_INIT;
                      rd_ptr_d = '0;
                      state_d  = S_RD;
                    end
                  end
                end
              end
            end
          endcase
        end
      end
      S_TX: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          out_d     = mk_tx(tx_b, idx_q == 3'd7);
          if (idx_q < 3'd6) begin
            crc_d = crc_step(crc_q, tx_b);
          end
          idx_d = idx_q + 3'd1;
          if (idx_q == 3'd7) begin
            state_d = S_CMD;
          end
        end
      end
      S_RD: begin
        if (rd_ptr_q != len_q) begin
          ram_re   = 1'b1;
          rd_ptr_d = rd_ptr_q + LW'(1);
          rd_vld_d = 1'b1;
          rd_idx_d = rd_ptr_q;
        end
        if (rd_vld_q) begin
          if (rd_idx_q < len_q - LW'(2)) begin
            crc_d = crc_step(crc_q, ram_rdata);
          end
          if (rd_idx_q == LW'(1)) begin
            exc_d = ram_rdata[EXC_BIT];
          end
          if (rd_idx_q == len_q - LW'(2)) begin
            got_d[7:0] = ram_rdata;
          end
          if (rd_idx_q == len_q - LW'(1)) begin
            got_d[15:8] = ram_rdata;
            state_d     = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (out_free) begin
          state_d = S_CMD;
          if (crc_q != got_q) begin
            out_vld_d = 1'b1;
            out_d     = mk_status(ST_CRC_ERR, 1'b0);
          end else if (exc_q) begin
            out_vld_d = 1'b1;
            out_d     = mk_status(ST_EXCEPTION, 1'b0);
          end else if (fsel_q == FS_READ && cnt_q != '0 && CMPW'(len_q) >= need_len) begin
            k_d     = '0;
            state_d = S_WA;
          end else begin
            out_vld_d = 1'b1;
            out_d     = mk_status(ST_OK, 1'b0);
          end
        end
      end
      S_WA: begin
        ram_re    = 1'b1;
        ram_raddr = waddr_w[AW-1:0];
        state_d   = S_WB;
      end
      S_WB: begin
        hi_d      = ram_rdata;
        ram_re    = 1'b1;
        ram_raddr = waddr_w[AW-1:0] + AW'(1);
        state_d   = S_WC;
      end
      S_WC: begin
        lo_d    = ram_rdata;
        state_d = S_WD;
      end
      S_WD: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          out_d     = mk_word({hi_q, lo_q}, k_q == cnt_q - CW'(1));
          k_d       = k_q + CW'(1);
          state_d   = (k_q == cnt_q - CW'(1)) ? S_CMD : S_WA;
        end
      end
      default: begin
        state_d = S_CMD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CMD;
      mode_q    <= MODE_IDLE;
      fsel_q    <= 2'd0;
      cnt_q     <= '0;
      len_q     <= '0;
      elapsed_q <= '0;
      silence_q <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      mode_q    <= mode_d;
      fsel_q    <= fsel_d;
      cnt_q     <= cnt_d;
      len_q     <= len_d;
      elapsed_q <= elapsed_d;
      silence_q <= silence_d;
      rd_vld_q  <= rd_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    frame_q  <= frame_d;
    crc_q    <= crc_d;
    idx_q    <= idx_d;
    rd_ptr_q <= rd_ptr_d;
    rd_idx_q <= rd_idx_d;
    exc_q    <= exc_d;
    got_q    <= got_d;
    k_q      <= k_d;
    hi_q     <= hi_d;
    lo_q     <= lo_d;
    out_q    <= out_d;
  end

endmodule

`default_nettype wire

FILE: design/modbus_rtu_master_transaction.sv
// ----------------------------------------------------------------------------
// modbus_rtu_master_transaction
// modbus rtu master: request framing with crc-16, reply capture and checking
// ----------------------------------------------------------------------------
// Events enter a front end that decodes them and builds the request frame
// fields, then wait in a two-entry queue for the back-end sequencer. Byte,
// tick and transmit-complete events are handled directly in its command
// state. A request puts out its eight frame bytes one per cycle while the
// result channel takes them, the crc computed byte by byte alongside. Ending
// a reply streams the receive buffer once through its single read port for
// the crc, then each register word of a good read is built from two buffer
// reads and put out. A result waits in an output register, so the back end
// only stalls when that register is still full.
`default_nettype none

module modbus_rtu_master_transaction #(
  parameter int RX_BUFFER_DEPTH = 256,
  parameter int MAX_READ_REGS   = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  mrm_evt_if.sink          evt_i,
  mrm_res_if.source        res_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);
  import mrm_pkg::*;

  logic [15:0] gap_q;
  logic [23:0] timeout_q;
  logic        cfg_we;
  logic        push, full, pop, q_vld;
  cmd_t        cmd_in, cmd_out;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  assign prdata = (paddr[2] == ADDR_TIMEOUT) ? {8'h00, timeout_q} : {16'h0000, gap_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q     <= GAP_RESET;
      timeout_q <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      if (paddr[2] == ADDR_GAP) begin
        gap_q <= pwdata[15:0];
      end else begin
        timeout_q <= pwdata[23:0];
      end
    end
  end

  mrm_front #(.MAX_READ_REGS(MAX_READ_REGS)) u_front (
    .evt_i  (evt_i),
    .push_o (push),
    .cmd_o  (cmd_in),
    .full_i (full)
  );

  mrm_queue #(.WIDTH($bits(cmd_t))) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (cmd_in),
    .full_o (full),
    .pop_i  (pop),
    .vld_o  (q_vld),
    .data_o (cmd_out)
  );

  mrm_back #(
    .RX_BUFFER_DEPTH (RX_BUFFER_DEPTH),
    .MAX_READ_REGS   (MAX_READ_REGS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_vld_i (q_vld),
    .cmd_i     (cmd_out),
    .cmd_pop_o (pop),
    .gap_i     (gap_q),
    .timeout_i (timeout_q),
    .res_o     (res_o)
  );

endmodule

`default_nettype wire

FILE: verif/modbus_rtu_master_transaction_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// modbus_rtu_master_transaction_tb
// self-checking bench for the modbus rtu master transaction engine
// ----------------------------------------------------------------------------
// Drives request, byte, tick and transmit-complete events into the master and
// predicts every frame byte, status and register word it should return. A
// short table covers the corner cases first. Random request/reply exchanges
// follow, with good, corrupted, short, exception and overlong replies, under
// several gap and timeout settings. Both channels idle at random.
// ----------------------------------------------------------------------------
`default_nettype none

module modbus_rtu_master_transaction_tb;
  import mrm_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 400;
  localparam int RX_DEPTH = 256;
  localparam int READ_CAP = 32;

  typedef enum logic [1:0] {
    LINK_IDLE,
    LINK_SEND,
    LINK_RECV
  } link_mode_e;

  typedef struct {
    evt_e        kind;
    logic [7:0]  sa;
    logic [1:0]  fs;
    logic [15:0] ra;
    logic [15:0] rv;
    logic [7:0]  rb;
  } bus_event_t;

  typedef struct {
    bus_event_t ev;
    bit         typed;
    res_t       want;
  } table_row_t;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  mrm_evt_if evt ();
  mrm_res_if res ();

  modbus_rtu_master_transaction DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .evt_i  (evt),
    .res_o  (res),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // predictor state
  link_mode_e  link_mode;
  logic [7:0]  reply_buf[RX_DEPTH];
  int unsigned reply_len;
  logic [23:0] elapsed;
  logic [15:0] silence;
  logic [1:0]  req_func;
  int unsigned req_count;
  logic [15:0] gap_cfg;
  logic [23:0] timeout_cfg;

  res_t        pending_results[$];
  int          errors;
  int          cycles;
  bit          calm;
  int          out_hold;
  int          sent;
  int          taken;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("modbus_rtu_master_transaction verification failed");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [15:0] crc16(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] x;
    x = c ^ {8'h00, b};
    repeat (8) x = x[0] ? ({1'b0, x[15:1]} ^ 16'hA001) : {1'b0, x[15:1]};
    return x;
  endfunction

  function automatic res_t status_item(input logic [2:0] st, input logic te);
    res_t r;
    r = '0;
    r.kind = 1'b1;
    r.status = st;
    r.last = 1'b1;
    r.te = te;
    return r;
  endfunction

  function automatic bus_event_t mk_ev(input evt_e k, input logic [7:0] sa,
                                       input logic [1:0] fs, input logic [15:0] ra,
                                       input logic [15:0] rv, input logic [7:0] rb);
    bus_event_t e;
    e.kind = k;
    e.sa = sa;
    e.fs = fs;
    e.ra = ra;
    e.rv = rv;
    e.rb = rb;
    return e;
  endfunction

  task automatic judge_reply();
    logic [15:0] c;
    logic [15:0] got;
    res_t        r;
    int unsigned n;
    n = reply_len;
    link_mode = LINK_IDLE;
    if (n < 4) begin
      pending_results.push_back(status_item(ST_SHORT, 1'b0));
      return;
    end
    c = 16'hFFFF;
    for (int i = 0; i < n - 2; i++) c = crc16(c, reply_buf[i]);
    got = {reply_buf[n-1], reply_buf[n-2]};
    if (c != got) begin
      pending_results.push_back(status_item(ST_CRC_ERR, 1'b0));
    end else if (reply_buf[1][7]) begin
      pending_results.push_back(status_item(ST_EXCEPTION, 1'b0));
    end else if (req_func == FS_READ && req_count > 0 && n - 3 >= 1 + 2 * req_count) begin
      for (int k = 0; k < req_count; k++) begin
        r = '0;
        r.kind = 1'b1;
        r.reg_word = {reply_buf[2+2*k], reply_buf[3+2*k]};
        r.data_valid = 1'b1;
        r.last = (k == req_count - 1);
        pending_results.push_back(r);
      end
    end else begin
      pending_results.push_back(status_item(ST_OK, 1'b0));
    end
  endtask

  task automatic predict_event(input bus_event_t e);
    logic [7:0]  f[8];
    logic [15:0] c;
    int unsigned cnt;
    res_t        r;
    case (e.kind)
      EV_REQUEST: begin
        if (link_mode != LINK_IDLE) begin
          pending_results.push_back(status_item(ST_BUSY, link_mode == LINK_SEND));
        end else if (e.fs != FS_NONE) begin
          f[0] = e.sa;
          f[2] = e.ra[15:8];
          f[3] = e.ra[7:0];
          if (e.fs == FS_READ) begin
            cnt = e.rv[7:0];
            if (cnt > READ_CAP) cnt = READ_CAP;
            f[1] = FC_READ_INPUT;
            f[4] = 8'h00;
            f[5] = cnt[7:0];
            req_count = cnt;
          end else if (e.fs == FS_WRITE) begin
            f[1] = FC_WRITE_REG;
            f[4] = e.rv[15:8];
            f[5] = e.rv[7:0];
            req_count = 0;
          end else begin
            f[1] = FC_WRITE_COIL;
            f[4] = (e.rv != 0) ? COIL_ON : 8'h00;
            f[5] = 8'h00;
            req_count = 0;
          end
          c = 16'hFFFF;
          for (int k = 0; k < 6; k++) c = crc16(c, f[k]);
          f[6] = c[7:0];
          f[7] = c[15:8];
          for (int k = 0; k < 8; k++) begin
            r = '0;
            r.tx_byte = f[k];
            r.last = (k == 7);
            r.te = 1'b1;
            pending_results.push_back(r);
          end
          req_func = e.fs;
          link_mode = LINK_SEND;
          reply_len = 0;
          elapsed = '0;
          silence = '0;
        end
      end
      EV_RX_BYTE: begin
        if (link_mode == LINK_RECV && reply_len < RX_DEPTH) begin
          reply_buf[reply_len] = e.rb;
          reply_len++;
          silence = '0;
        end
      end
      EV_TX_DONE: begin
        if (link_mode == LINK_SEND) begin
          link_mode = LINK_RECV;
          reply_len = 0;
          silence = '0;
        end
      end
      default: begin
        if (link_mode != LINK_IDLE) begin
          if (elapsed != 24'hFFFFFF) elapsed++;
          if (elapsed > timeout_cfg) begin
            link_mode = LINK_IDLE;
            pending_results.push_back(status_item(ST_TIMEOUT, 1'b0));
          end else if (link_mode == LINK_RECV && reply_len > 0) begin
            if (silence != 16'hFFFF) silence++;
            if (silence > gap_cfg) judge_reply();
          end
        end
      end
    endcase
  endtask

  // drives one event and predicts it once the transaction is taken
  task automatic send_event(input bus_event_t e);
    int g;
    g = gap_len();
    if (g > 0) begin
      evt.valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    evt.valid <= 1'b1;
    evt.event_kind <= e.kind;
    evt.slave_addr <= e.sa;
    evt.function_select <= e.fs;
    evt.reg_addr <= e.ra;
    evt.request_value <= e.rv;
    evt.rx_byte <= e.rb;
    do @(posedge clk); while (!evt.ready);
    predict_event(e);
    sent++;
    @(negedge clk);
  endtask

  task automatic tick();
    send_event(mk_ev(EV_TICK, 8'($urandom), 2'($urandom), 16'($urandom), 16'($urandom),
                     8'($urandom)));
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_event(mk_ev(EV_RX_BYTE, 8'($urandom), 2'($urandom), 16'($urandom), 16'($urandom),
                     b));
  endtask

  task automatic reg_write(input logic idx, input logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == ADDR_GAP) gap_cfg = value[15:0];
    else timeout_cfg = value[23:0];
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic drain();
    evt.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // one request/reply exchange with random content
  task automatic random_exchange(input bit overlong);
    bus_event_t  req;
    logic [7:0]  reply[$];
    logic [15:0] c;
    int          pick;
    int          cnt;
    int          ndata;
    int          pause;
    calm = ($urandom_range(0, 3) == 0);
    req = mk_ev(EV_REQUEST, 8'($urandom), $urandom_range(0, 9) == 0 ? FS_NONE :
                2'($urandom_range(0, 2)), 16'($urandom), 16'($urandom), 8'($urandom));
    pick = $urandom_range(0, 9);
    if (req.fs == FS_READ)
      req.rv[7:0] = (pick < 8) ? 8'($urandom_range(0, 5)) : 8'($urandom_range(0, 255));
    if (req.fs == FS_COIL && pick < 3) req.rv = '0;
    send_event(req);
    if (req.fs == FS_NONE) return;
    if ($urandom_range(0, 19) == 0) send_event(mk_ev(EV_REQUEST, 8'($urandom),
                                                     2'($urandom), 16'($urandom),
                                                     16'($urandom), 8'($urandom)));
    if (timeout_cfg <= 64 && $urandom_range(0, 5) == 0) begin
      while (link_mode != LINK_IDLE) tick();
      return;
    end
    if ($urandom_range(0, 9) == 0) send_byte(8'($urandom));
    send_event(mk_ev(EV_TX_DONE, 8'($urandom), 2'($urandom), 16'($urandom), 16'($urandom),
                     8'($urandom)));
    pick = $urandom_range(0, 99);
    reply.push_back(req.sa);
    if (overlong) begin
      repeat (RX_DEPTH + 6) reply.push_back(8'($urandom));
    end else if (pick < 10) begin
      reply = {};
      repeat ($urandom_range(1, 3)) reply.push_back(8'($urandom));
    end else begin
      if (pick < 20) begin
        reply.push_back({1'b1, 7'($urandom)});
        reply.push_back(8'($urandom));
      end else if (req.fs == FS_READ) begin
        cnt = (req.rv[7:0] > READ_CAP) ? READ_CAP : req.rv[7:0];
        ndata = (pick < 30) ? $urandom_range(0, 2 * cnt) : 2 * cnt;
        reply.push_back(FC_READ_INPUT);
        reply.push_back(8'(2 * cnt));
        repeat (ndata) reply.push_back(8'($urandom));
      end else begin
        reply.push_back(req.fs == FS_WRITE ? FC_WRITE_REG : FC_WRITE_COIL);
        repeat (4) reply.push_back(8'($urandom));
      end
      c = 16'hFFFF;
      foreach (reply[i]) c = crc16(c, reply[i]);
      reply.push_back(c[7:0]);
      reply.push_back(c[15:8]);
      if (pick >= 90) reply[$urandom_range(0, reply.size() - 1)] ^= 8'(1 << $urandom_range(0, 7));
    end
    foreach (reply[i]) begin
      send_byte(reply[i]);
      pause = overlong ? 0 : $urandom_range(0, gap_cfg > 3 ? 3 : gap_cfg);
      repeat (pause) tick();
    end
    while (link_mode != LINK_IDLE) tick();
  endtask

  always @(negedge clk) begin
    if (out_hold > 0) begin
      out_hold <= out_hold - 1;
      res.ready <= 1'b0;
    end else begin
      out_hold <= gap_len();
      res.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    res_t want;
    if (rst_n && res.valid && res.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result item");
        errors++;
      end else begin
        want = pending_results.pop_front();
        taken++;
        if (res.item_kind !== want.kind) begin
          $error("item_kind: expected %0d, got %0d", want.kind, res.item_kind);
          errors++;
        end
        if (res.tx_byte !== want.tx_byte) begin
          $error("tx_byte: expected %0h, got %0h", want.tx_byte, res.tx_byte);
          errors++;
        end
        if (res.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, res.status);
          errors++;
        end
        if (res.reg_word !== want.reg_word) begin
          $error("reg_word: expected %0h, got %0h", want.reg_word, res.reg_word);
          errors++;
        end
        if (res.data_valid !== want.data_valid) begin
          $error("data_valid: expected %0d, got %0d", want.data_valid, res.data_valid);
          errors++;
        end
        if (res.last_of_run !== want.last) begin
          $error("last_of_run: expected %0d, got %0d", want.last, res.last_of_run);
          errors++;
        end
        if (res.transmit_enable !== want.te) begin
          $error("transmit_enable: expected %0d, got %0d", want.te, res.transmit_enable);
          errors++;
        end
      end
    end
  end

  initial begin
    table_row_t  rows[$];
    table_row_t  row;
    int          before_size;
    int          taken_before;
    logic [15:0] gap_plan[6];
    logic [23:0] timeout_plan[6];

    calm = 1'b0;
    rst_n = 1'b0;
    evt.valid = 1'b0;
    evt.event_kind = EV_REQUEST;
    evt.slave_addr = '0;
    evt.function_select = '0;
    evt.reg_addr = '0;
    evt.request_value = '0;
    evt.rx_byte = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    link_mode = LINK_IDLE;
    reply_len = 0;
    elapsed = '0;
    silence = '0;
    req_func = FS_READ;
    req_count = 0;
    gap_cfg = GAP_RESET;
    timeout_cfg = TIMEOUT_RESET;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    reg_write(ADDR_GAP, 32'd2);
    reg_write(ADDR_TIMEOUT, 32'd3);

    // corner cases: stray events, clamp, busy, short reply, timeout, crc error
    row.typed = 1'b0;
    row.want = '0;
    row.ev = mk_ev(EV_TICK, 0, 0, 0, 0, 0);                 rows.push_back(row);
    row.ev = mk_ev(EV_RX_BYTE, 0, 0, 0, 0, 8'hAA);          rows.push_back(row);
    row.ev = mk_ev(EV_TX_DONE, 0, 0, 0, 0, 0);              rows.push_back(row);
    row.ev = mk_ev(EV_REQUEST, 8'h11, FS_NONE, 16'h1234, 16'h5, 0); rows.push_back(row);
    row.ev = mk_ev(EV_REQUEST, 8'hFF, FS_READ, 16'hFFFF, 16'h00FF, 0); rows.push_back(row);
    row.typed = 1'b1;
    row.want = status_item(ST_BUSY, 1'b1);
    row.ev = mk_ev(EV_REQUEST, 8'h01, FS_WRITE, 16'h0, 16'h0, 0); rows.push_back(row);
    row.typed = 1'b0;
    row.ev = mk_ev(EV_TX_DONE, 0, 0, 0, 0, 0);              rows.push_back(row);
    row.typed = 1'b1;
    row.want = status_item(ST_BUSY, 1'b0);
    row.ev = mk_ev(EV_REQUEST, 8'h01, FS_COIL, 16'h0, 16'h1, 0); rows.push_back(row);
    row.typed = 1'b0;
    row.ev = mk_ev(EV_RX_BYTE, 0, 0, 0, 0, 8'h01);          rows.push_back(row);
    row.ev = mk_ev(EV_RX_BYTE, 0, 0, 0, 0, 8'h84);          rows.push_back(row);
    row.ev = mk_ev(EV_RX_BYTE, 0, 0, 0, 0, 8'h02);          rows.push_back(row);
    row.ev = mk_ev(EV_TICK, 0, 0, 0, 0, 0);                 rows.push_back(row);
    rows.push_back(row);
    row.typed = 1'b1;
    row.want = status_item(ST_SHORT, 1'b0);
    rows.push_back(row);
    row.typed = 1'b0;
    row.ev = mk_ev(EV_REQUEST, 8'h00, FS_COIL, 16'h0000, 16'h0001, 0); rows.push_back(row);
    row.ev = mk_ev(EV_TICK, 0, 0, 0, 0, 0);                 rows.push_back(row);
    rows.push_back(row);
    rows.push_back(row);
    row.typed = 1'b1;
    row.want = status_item(ST_TIMEOUT, 1'b0);
    rows.push_back(row);
    row.typed = 1'b0;
    row.ev = mk_ev(EV_REQUEST, 8'h00, FS_WRITE, 16'h0000, 16'hFFFF, 0); rows.push_back(row);
    row.ev = mk_ev(EV_TX_DONE, 0, 0, 0, 0, 0);              rows.push_back(row);
    row.ev = mk_ev(EV_RX_BYTE, 0, 0, 0, 0, 8'h00);          rows.push_back(row);
    rows.push_back(row);
    rows.push_back(row);
    rows.push_back(row);
    row.ev = mk_ev(EV_TICK, 0, 0, 0, 0, 0);                 rows.push_back(row);
    rows.push_back(row);
    row.typed = 1'b1;
    row.want = status_item(ST_CRC_ERR, 1'b0);
    rows.push_back(row);

    foreach (rows[i]) begin
      before_size = pending_results.size();
      taken_before = taken;
      send_event(rows[i].ev);
      if (rows[i].typed) begin
        while (pending_results.size() + (taken - taken_before) > before_size)
          void'(pending_results.pop_back());
        pending_results.push_back(rows[i].want);
      end
    end

    gap_plan = '{16'd0, 16'hFFFF, 16'd5, 16'd1, 16'd8, 16'd3};
    timeout_plan = '{24'hFFFFFF, 24'd20, 24'd1000, 24'd0, 24'd48, 24'd1000};
    foreach (gap_plan[p]) begin
      drain();
      reg_write(ADDR_GAP, {16'h0, gap_plan[p]});
      reg_write(ADDR_TIMEOUT, {8'h0, timeout_plan[p]});
      if (p == 5) random_exchange(1'b1);
      do begin
        random_exchange(1'b0);
      end while (sent < 20 * (p + 2));
    end

    calm = 1'b0;
    evt.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("modbus_rtu_master_transaction verification clean");
    end else begin
      $display("modbus_rtu_master_transaction verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
